>>> rtl/sps_pkg.sv
`timescale 1ns / 1ps

package sps_pkg;

  localparam int REQ_TYPE_W = 2;
  localparam int RAND_W     = 31;
  localparam int PCT_W      = 15;
  localparam int SAMPLE_W   = 6;
  localparam int TOTAL_W    = 7;
  localparam int POP_W      = 7;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 15;

  localparam logic [POP_W-1:0] POP_RESET      = 7'd64;
  localparam logic [PCT_W-1:0] INIT_PCT_RESET = 15'd1280;

  // percent in q7.8: value * pct / 25600, rounded half up
  localparam int PCT_FRAC    = 8;
  localparam int PCT_HALF    = 12800;
  // divide by 100 as multiply by reciprocal, exact for the operand range used
  localparam int RECIP_W     = 13;
  localparam logic [RECIP_W-1:0] RECIP = 13'd5243;
  localparam int RECIP_SHIFT = 19;
  localparam int MIN_ADD     = 2;

  typedef enum logic [REQ_TYPE_W-1:0] {
    REQ_RESTART = 2'd0,
    REQ_SHUFFLE = 2'd1,
    REQ_EXPAND  = 2'd2
  } req_type_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POP_SIZE = 4'd0,
    CFG_INIT_PCT = 4'd1
  } cfg_idx_e;

  typedef struct packed {
    logic accept;
    logic restart;
    logic div_step;
    logic rd_j;
    logic rd_k;
    logic wr_j;
    logic wr_k;
    logic mul1;
    logic mul2;
    logic plan;
    logic rd_cur;
    logic emit;
  } sps_cmd_t;

  typedef struct packed {
    logic shuf_done;
    logic div_last;
    logic plan_empty;
    logic emit_last;
    logic out_free;
  } sps_status_t;

endpackage

>>> rtl/sps_req_if.sv
`timescale 1ns / 1ps

interface sps_req_if import sps_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [REQ_TYPE_W-1:0] req_type;
  logic [RAND_W-1:0]     rand_word;
  logic [PCT_W-1:0]      add_percent;

  modport source (output valid, req_type, rand_word, add_percent, input ready);
  modport sink   (input valid, req_type, rand_word, add_percent, output ready);
endinterface

>>> rtl/sps_res_if.sv
`timescale 1ns / 1ps

interface sps_res_if import sps_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample_index;
  logic                last_of_run;
  logic [TOTAL_W-1:0]  selected_total;

  modport source (output valid, sample_index, last_of_run, selected_total, input ready);
  modport sink   (input valid, sample_index, last_of_run, selected_total, output ready);
endinterface

>>> rtl/sps_cfg_if.sv
`timescale 1ns / 1ps

interface sps_cfg_if import sps_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/shuffled_progressive_sampler_top.sv
`timescale 1ns / 1ps

// channel  dir  role    word
// req_i    in   sink    req_type, rand_word, add_percent
// res_o    out  source  sample_index, last_of_run, selected_total
// cfg_i    in   sink    index, data (always ready)
//
// restart completes on acceptance; an expand request runs mul1, mul2, plan,
// then a read and an emit per index; a shuffle step runs the bit-serial
// remainder, then a swap through the permutation memory's single write port
// reset marks every permutation entry unwritten, which reads as identity
// a stalled result holds in the output register and blocks further emits
module shuffled_progressive_sampler_top import sps_pkg::*; #(
  parameter int MAX_POPULATION = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sps_req_if.sink   req_i,
  sps_res_if.source res_o,
  sps_cfg_if.sink   cfg_i
);

  sps_cmd_t    cmd;
  sps_status_t status;
  logic        in_ready;

  assign req_i.ready = in_ready;

  sps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .req_type_i (req_i.req_type),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sps_dp #(
    .MAX_POPULATION (MAX_POPULATION)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rand_word_i   (req_i.rand_word),
    .add_percent_i (req_i.add_percent),
    .cmd_i         (cmd),
    .status_o      (status),
    .res_o         (res_o),
    .cfg_i         (cfg_i)
  );

endmodule

>>> rtl/sps_ctrl.sv
`timescale 1ns / 1ps

module sps_ctrl import sps_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic [REQ_TYPE_W-1:0] req_type_i,
  output logic                  in_ready_o,
  input  sps_status_t           status_i,
  output sps_cmd_t              cmd_o
);

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_DIV  = 11'b000_0000_0010,
    S_RDJ  = 11'b000_0000_0100,
    S_RDK  = 11'b000_0000_1000,
    S_WRJ  = 11'b000_0001_0000,
    S_WRK  = 11'b000_0010_0000,
    S_MUL1 = 11'b000_0100_0000,
    S_MUL2 = 11'b000_1000_0000,
    S_PLAN = 11'b001_0000_0000,
    S_RD   = 11'b010_0000_0000,
    S_EMIT = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          case (req_type_i)
            REQ_RESTART: cmd_o.restart = 1'b1;
            REQ_SHUFFLE: begin
              if (!status_i.shuf_done) state_d = S_DIV;
            end
            REQ_EXPAND: state_d = S_MUL1;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) state_d = S_RDJ;
      end
      S_RDJ: begin
        cmd_o.rd_j = 1'b1;
        state_d    = S_RDK;
      end
      S_RDK: begin
        cmd_o.rd_k = 1'b1;
        state_d    = S_WRJ;
      end
      S_WRJ: begin
        cmd_o.wr_j = 1'b1;
        state_d    = S_WRK;
      end
      S_WRK: begin
        cmd_o.wr_k = 1'b1;
        state_d    = S_IDLE;
      end
      S_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = S_PLAN;
      end
      S_PLAN: begin
        cmd_o.plan = 1'b1;
        state_d    = status_i.plan_empty ? S_IDLE : S_RD;
      end
      S_RD: begin
        cmd_o.rd_cur = 1'b1;
        state_d      = S_EMIT;
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = status_i.emit_last ? S_IDLE : S_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/sps_dp.sv
`timescale 1ns / 1ps

module sps_dp import sps_pkg::*; #(
  parameter int MAX_POPULATION = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [RAND_W-1:0] rand_word_i,
  input  logic [PCT_W-1:0]  add_percent_i,
  input  sps_cmd_t          cmd_i,
  output sps_status_t       status_o,
  sps_res_if.source         res_o,
  sps_cfg_if.sink           cfg_i
);

  localparam int IDX_W     = $clog2(MAX_POPULATION);
  localparam int CNT_W     = $clog2(MAX_POPULATION + 1);
  localparam int DIV_CNT_W = $clog2(RAND_W);
  localparam int PROD1_W   = CNT_W + PCT_W;
  localparam int Y_W       = PROD1_W - PCT_FRAC;
  localparam int P2_W      = Y_W + RECIP_W;
  localparam int ADD_W     = P2_W - RECIP_SHIFT;
  localparam int SUM_W     = ADD_W + 1;
  localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAX_POPULATION);

  // configuration registers
  logic [POP_W-1:0] pop_size_q;
  logic [PCT_W-1:0] init_pct_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop_size_q <= POP_RESET;
      init_pct_q <= INIT_PCT_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_POP_SIZE: pop_size_q <= cfg_i.data[POP_W-1:0];
        CFG_INIT_PCT: init_pct_q <= cfg_i.data[PCT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  logic [CNT_W-1:0] n_eff;
  logic [CNT_W-1:0] c_eff;
  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] j_q;

  always_comb begin
    if (pop_size_q == '0) begin
      n_eff = CNT_W'(1);
    end else if (pop_size_q > POP_W'(MAX_POPULATION)) begin
      n_eff = MAX_N;
    end else begin
      n_eff = CNT_W'(pop_size_q);
    end
  end

  assign c_eff = (count_q > n_eff) ? n_eff : count_q;

  // serial remainder, one dividend bit per cycle
  logic [RAND_W-1:0]    dividend_q;
  logic [CNT_W-1:0]     d_q;
  logic [CNT_W-1:0]     rem_q;
  logic [DIV_CNT_W-1:0] div_cnt_q;
  logic [CNT_W:0]       trial;
  logic [CNT_W-1:0]     rem_next;

  assign trial    = {rem_q, dividend_q[RAND_W-1]};
  assign rem_next = (trial >= {1'b0, d_q}) ? CNT_W'(trial - {1'b0, d_q}) : CNT_W'(trial);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      dividend_q <= rand_word_i;
      rem_q      <= '0;
      div_cnt_q  <= '0;
      d_q        <= n_eff - j_q;
    end else if (cmd_i.div_step) begin
      dividend_q <= dividend_q << 1;
      rem_q      <= rem_next;
      div_cnt_q  <= div_cnt_q + DIV_CNT_W'(1);
    end
  end

  logic [CNT_W-1:0] k_sum;
  logic [IDX_W-1:0] j_idx;
  logic [IDX_W-1:0] k_idx;

  assign k_sum = j_q + rem_q;
  assign j_idx = j_q[IDX_W-1:0];
  assign k_idx = k_sum[IDX_W-1:0];

  // permutation store, entries not yet written read as their own index
  logic [IDX_W-1:0]          perm_mem [MAX_POPULATION];
  logic [MAX_POPULATION-1:0] vld_q;
  logic [IDX_W-1:0]          rd_data_q;
  logic [IDX_W-1:0]          rd_addr_q;
  logic                      rd_vld_q;
  logic [IDX_W-1:0]          rd_val;
  logic [IDX_W-1:0]          rd_addr;
  logic                      rd_en;
  logic [IDX_W-1:0]          wr_addr;
  logic [IDX_W-1:0]          wr_data;
  logic                      wr_en;
  logic [IDX_W-1:0]          tmp_q;
  logic [CNT_W-1:0]          cur_q;
  logic [CNT_W-1:0]          stop_q;

  always_comb begin
    if (cmd_i.rd_k) begin
      rd_addr = k_idx;
    end else if (cmd_i.rd_cur) begin
      rd_addr = cur_q[IDX_W-1:0];
    end else begin
      rd_addr = j_idx;
    end
  end

  assign rd_en   = cmd_i.rd_j | cmd_i.rd_k | cmd_i.rd_cur;
  assign wr_en   = cmd_i.wr_j | cmd_i.wr_k;
  assign wr_addr = cmd_i.wr_k ? k_idx : j_idx;
  assign wr_data = cmd_i.wr_k ? tmp_q : rd_val;
  assign rd_val  = rd_vld_q ? rd_data_q : rd_addr_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      perm_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= perm_mem[rd_addr];
      rd_vld_q  <= vld_q[rd_addr];
      rd_addr_q <= rd_addr;
    end
    if (cmd_i.rd_k) begin
      tmp_q <= rd_val;
    end
  end

  // subset size arithmetic
  logic [PCT_W-1:0]   pct_q;
  logic [PROD1_W-1:0] prod1_q;
  logic [P2_W-1:0]    prod2_q;
  logic [CNT_W-1:0]   mul_v;
  logic [PCT_W-1:0]   mul_p;
  logic [ADD_W-1:0]   add_raw;
  logic [ADD_W-1:0]   add_adj;
  logic [SUM_W-1:0]   sum;
  logic [CNT_W-1:0]   stop_d;

  assign mul_v   = (c_eff == '0) ? n_eff : c_eff;
  assign mul_p   = (c_eff == '0) ? init_pct_q : pct_q;
  assign add_raw = prod2_q[P2_W-1:RECIP_SHIFT];
  assign add_adj = (add_raw == '0 && c_eff != n_eff) ? ADD_W'(MIN_ADD) : add_raw;
  assign sum     = SUM_W'(c_eff) + SUM_W'(add_adj);
  assign stop_d  = (sum >= SUM_W'(n_eff)) ? n_eff : CNT_W'(sum);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      pct_q <= add_percent_i;
    end
    if (cmd_i.mul1) begin
      prod1_q <= PROD1_W'(mul_v) * PROD1_W'(mul_p) + PROD1_W'(PCT_HALF);
    end
    if (cmd_i.mul2) begin
      prod2_q <= P2_W'(prod1_q[PROD1_W-1:PCT_FRAC]) * P2_W'(RECIP);
    end
    if (cmd_i.plan) begin
      cur_q  <= c_eff;
      stop_q <= stop_d;
    end else if (cmd_i.emit) begin
      cur_q <= cur_q + CNT_W'(1);
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      j_q     <= '0;
      count_q <= '0;
    end else if (cmd_i.restart) begin
      vld_q   <= '0;
      j_q     <= '0;
      count_q <= '0;
    end else begin
      if (wr_en) vld_q[wr_addr] <= 1'b1;
      if (cmd_i.wr_k) j_q <= j_q + CNT_W'(1);
      if (cmd_i.plan) count_q <= stop_d;
    end
  end

  // output register
  logic                out_valid_q;
  logic [SAMPLE_W-1:0] out_index_q;
  logic                out_last_q;
  logic [TOTAL_W-1:0]  out_total_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_index_q <= SAMPLE_W'(rd_val);
      out_last_q  <= status_o.emit_last;
      out_total_q <= TOTAL_W'(stop_q);
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.sample_index   = out_index_q;
  assign res_o.last_of_run    = out_last_q;
  assign res_o.selected_total = out_total_q;

  assign status_o.shuf_done  = (j_q + CNT_W'(1)) >= n_eff;
  assign status_o.div_last   = div_cnt_q == DIV_CNT_W'(RAND_W - 1);
  assign status_o.plan_empty = stop_d == c_eff;
  assign status_o.emit_last  = (cur_q + CNT_W'(1)) == stop_q;
  assign status_o.out_free   = !out_valid_q || res_o.ready;

endmodule

>>> bench/sps_checker.sv
`timescale 1ns / 1ps

module sps_checker import sps_pkg::*; #(
  parameter int MAX_POPULATION = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  sps_req_if   req_i,
  sps_res_if   res_i,
  sps_cfg_if   cfg_i,
  output int   fail_count_o,
  output int   pending_o
);

  localparam int unsigned PCT_DENOM = 100 << PCT_FRAC;

  typedef struct packed {
    logic [SAMPLE_W-1:0] index;
    logic                last;
    logic [TOTAL_W-1:0]  total;
  } pick_t;

  pick_t               picks_due[$];
  logic [SAMPLE_W-1:0] order [MAX_POPULATION];
  logic [TOTAL_W-1:0]  walk_pos;
  logic [TOTAL_W-1:0]  taken;
  logic [POP_W-1:0]    pop_reg = POP_RESET;
  logic [PCT_W-1:0]    init_pct_reg = INIT_PCT_RESET;
  int                  fails = 0;

  function automatic int unsigned live_pop();
    if (pop_reg == 0) return 1;
    if (pop_reg > MAX_POPULATION) return MAX_POPULATION;
    return pop_reg;
  endfunction

  function automatic void load_identity();
    for (int i = 0; i < MAX_POPULATION; i++) order[i] = SAMPLE_W'(i);
    walk_pos = '0;
    taken    = '0;
  endfunction

  function automatic void swap_step(input logic [RAND_W-1:0] r);
    int unsigned         n, j, k;
    logic [SAMPLE_W-1:0] t;
    n = live_pop();
    j = walk_pos;
    if (j + 1 >= n) return;
    k = j + (r % (n - j));
    t        = order[j];
    order[j] = order[k];
    order[k] = t;
    walk_pos = TOTAL_W'(j + 1);
  endfunction

  function automatic void grow_subset(input logic [PCT_W-1:0] pct);
    int unsigned n, c, add, stop;
    n = live_pop();
    c = taken;
    if (c > n) c = n;
    if (c == 0) add = (n * init_pct_reg + PCT_HALF) / PCT_DENOM;
    else add = (c * pct + PCT_HALF) / PCT_DENOM;
    if (add == 0 && c != n) add = MIN_ADD;
    stop = (c + add >= n) ? n : c + add;
    for (int unsigned i = c; i < stop; i++)
      picks_due.push_back('{index: order[i], last: (i + 1 == stop), total: TOTAL_W'(stop)});
    taken = TOTAL_W'(stop);
  endfunction

  initial load_identity();

  always @(posedge clk_i) begin : watch
    pick_t want;
    if (!rst_ni) begin
      pop_reg      = POP_RESET;
      init_pct_reg = INIT_PCT_RESET;
      load_identity();
      picks_due.delete();
    end else begin
      if (res_i.valid && res_i.ready) begin
        if (picks_due.size() == 0) begin
          $error("word with nothing expected: sample_index %0d last_of_run %0d selected_total %0d",
                 res_i.sample_index, res_i.last_of_run, res_i.selected_total);
          fails++;
        end else begin
          want = picks_due.pop_front();
          if (res_i.sample_index !== want.index) begin
            $error("sample_index expected %0d actual %0d", want.index, res_i.sample_index);
            fails++;
          end
          if (res_i.last_of_run !== want.last) begin
            $error("last_of_run expected %0d actual %0d", want.last, res_i.last_of_run);
            fails++;
          end
          if (res_i.selected_total !== want.total) begin
            $error("selected_total expected %0d actual %0d", want.total, res_i.selected_total);
            fails++;
          end
        end
      end
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CFG_POP_SIZE: pop_reg = cfg_i.data[POP_W-1:0];
          CFG_INIT_PCT: init_pct_reg = cfg_i.data[PCT_W-1:0];
          default: ;
        endcase
      end
      if (req_i.valid && req_i.ready) begin
        case (req_i.req_type)
          REQ_RESTART: load_identity();
          REQ_SHUFFLE: swap_step(req_i.rand_word);
          REQ_EXPAND:  grow_subset(req_i.add_percent);
          default: ;
        endcase
      end
    end
    fail_count_o = fails;
    pending_o    = picks_due.size();
  end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top import sps_pkg::*; ();

  localparam int MAX_POPULATION = 64;
  localparam int SETTLE_CYCLES  = 48;
  localparam int ITEM_TARGET    = 370;
  localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED     = 2'd3;
  localparam logic [CFG_IDX_W-1:0]  CFG_IDX_UNUSED = '1;
  localparam logic [PCT_W-1:0]      PCT_FULL       = 15'd25600;
  localparam logic [PCT_W-1:0]      PCT_HALF_WAY   = 15'd12800;

  logic clk_i = 1'b0;
  logic rst_ni;
  int   fail_count;
  int   pending_words;
  int   items_sent = 0;
  bit   calm = 1'b0;

  sps_req_if req_if ();
  sps_res_if res_if ();
  sps_cfg_if cfg_if ();

  shuffled_progressive_sampler_top #(.MAX_POPULATION(MAX_POPULATION)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  sps_checker #(.MAX_POPULATION(MAX_POPULATION)) chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_if),
    .res_i        (res_if),
    .cfg_i        (cfg_if),
    .fail_count_o (fail_count),
    .pending_o    (pending_words)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    res_if.ready <= calm || ($urandom_range(99) >= 31);
  end

  function automatic logic [RAND_W-1:0] rand_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return RAND_W'($urandom);
    endcase
  endfunction

  function automatic logic [PCT_W-1:0] pick_pct();
    case ($urandom_range(7))
      0:       return '0;
      1:       return PCT_FULL;
      2:       return PCT_W'($urandom_range(0, 3000));
      default: return PCT_W'($urandom_range(0, PCT_FULL));
    endcase
  endfunction

  // valid stays high after a handshake until the next call or a settle lowers it
  task automatic send_req(input logic [REQ_TYPE_W-1:0] kind, input logic [RAND_W-1:0] word,
                          input logic [PCT_W-1:0] pct);
    if (items_sent >= ITEM_TARGET) begin
      req_if.valid <= 1'b0;
      return;
    end
    while (!calm && $urandom_range(99) < 31) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.req_type    <= kind;
    req_if.rand_word   <= word;
    req_if.add_percent <= pct;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
    calm = (items_sent >= 150 && items_sent < 230);
  endtask

  task automatic settle();
    req_if.valid <= 1'b0;
    while (pending_words != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    settle();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    logic [POP_W-1:0] pop;
    int               n, walk, steps;
    rst_ni             <= 1'b0;
    req_if.valid       <= 1'b0;
    req_if.req_type    <= REQ_RESTART;
    req_if.rand_word   <= '0;
    req_if.add_percent <= '0;
    cfg_if.valid       <= 1'b0;
    cfg_if.index       <= CFG_POP_SIZE;
    cfg_if.data        <= '0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset registers, identity order
    send_req(REQ_EXPAND, '0, '0);
    send_req(REQ_EXPAND, '0, '0);
    send_req(REQ_EXPAND, '0, PCT_FULL);
    send_req(REQ_EXPAND, '1, PCT_HALF_WAY);
    repeat (4) send_req(REQ_EXPAND, '0, PCT_FULL);
    send_req(REQ_UNUSED, '1, '1);
    send_req(REQ_RESTART, '1, '1);
    send_req(REQ_SHUFFLE, '0, '0);
    send_req(REQ_SHUFFLE, '1, '0);
    send_req(REQ_SHUFFLE, 31'h5555_5555, '0);
    send_req(REQ_EXPAND, '0, PCT_FULL);
    // population of one, zero percent
    write_reg(CFG_IDX_UNUSED, '1);
    write_reg(CFG_POP_SIZE, '0);
    write_reg(CFG_INIT_PCT, '0);
    send_req(REQ_RESTART, '0, '0);
    send_req(REQ_SHUFFLE, '1, '0);
    send_req(REQ_EXPAND, '0, '0);
    send_req(REQ_EXPAND, '0, '0);
    // population of two, walk ends after one step
    write_reg(CFG_POP_SIZE, 15'd2);
    write_reg(CFG_INIT_PCT, PCT_FULL);
    send_req(REQ_RESTART, '0, '0);
    send_req(REQ_SHUFFLE, '1, '0);
    send_req(REQ_SHUFFLE, '1, '0);
    send_req(REQ_EXPAND, '0, '0);
    // oversize population, then shrink below the count
    write_reg(CFG_POP_SIZE, 15'h7fff);
    send_req(REQ_RESTART, '0, '0);
    send_req(REQ_EXPAND, '0, '0);
    write_reg(CFG_POP_SIZE, 15'd4);
    send_req(REQ_EXPAND, '0, PCT_FULL);
    send_req(REQ_EXPAND, '0, PCT_FULL);

    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(11))
        0:       pop = '0;
        1:       pop = POP_W'($urandom_range(65, 127));
        2, 3:    pop = POP_W'(MAX_POPULATION);
        4:       pop = 7'd1;
        default: pop = POP_W'($urandom_range(2, 16));
      endcase
      n = (pop == 0) ? 1 : (pop > MAX_POPULATION) ? MAX_POPULATION : pop;
      write_reg(CFG_POP_SIZE, {8'($urandom), pop});
      write_reg(CFG_INIT_PCT, pick_pct());
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(99) < 85) begin
          send_req(REQ_RESTART, rand_word(), pick_pct());
          walk  = (n > 1) ? n - 1 : 0;
          steps = ($urandom_range(3) == 0) ? $urandom_range(0, walk + 2) : walk;
          repeat (steps) send_req(REQ_SHUFFLE, rand_word(), pick_pct());
          repeat ($urandom_range(1, 10)) send_req(REQ_EXPAND, rand_word(), pick_pct());
        end else begin
          repeat ($urandom_range(1, 6))
            send_req(REQ_TYPE_W'($urandom_range(3)), rand_word(), pick_pct());
        end
        if ($urandom_range(4) == 0) settle();
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
